### hw/rtl/kcde_pkg.sv
// ----------------------------------------------------------------------------
// kcde_pkg
// Shared types and constants of the key change delta encoder: the frame and
// codeword payloads and the job entry handed from the front to the back.
// ----------------------------------------------------------------------------
package kcde_pkg;

	// Fixed field widths of the frame and codeword payloads.
	localparam int PLAYER_W  = 2;
	localparam int KEYS_W    = 10;
	localparam int WORD_W    = 32;
	localparam int CODE_W    = 32;
	localparam int LEN_W     = 6;
	localparam int KEY_IDX_W = $clog2(KEYS_W);

	// Defaults of the top level parameters.
	localparam int NUM_KEYS_DEF    = 10;
	localparam int INDEX_BITS_DEF  = 4;
	localparam int NUM_PLAYERS_DEF = 4;

	// Codeword lengths of the end marker and the raw movement words.
	localparam logic [LEN_W-1:0] END_LEN  = LEN_W'(1);
	localparam logic [LEN_W-1:0] WORD_LEN = LEN_W'(WORD_W);

	// Depth of the job queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One input frame.
	typedef struct packed {
		logic [PLAYER_W-1:0] player;
		logic [KEYS_W-1:0]   keys;
		logic [WORD_W-1:0]   x_bits;
		logic [WORD_W-1:0]   y_bits;
	} frame_t;

	// One emitted codeword.
	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  code_len;
		logic              last;
	} code_word_t;

	// Classified frame: the changed keys and the raw words to pass through.
	typedef struct packed {
		logic [KEYS_W-1:0] diff;
		logic [WORD_W-1:0] x_bits;
		logic [WORD_W-1:0] y_bits;
	} job_t;

endpackage

### hw/rtl/kcde_queue.sv
// ----------------------------------------------------------------------------
// kcde_queue
// Small first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module kcde_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  kcde_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output kcde_pkg::job_t head,
	output logic          not_empty
);
	import kcde_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t              entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entries_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	// Entry storage, written at the tail.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/kcde_front.sv
// ----------------------------------------------------------------------------
// kcde_front
// Accepts frames, compares the key bitmap with the stored bitmap of the
// player, updates that bitmap and hands the changed keys to the queue.
// ----------------------------------------------------------------------------
module kcde_front #(
	parameter int NUM_KEYS    = kcde_pkg::NUM_KEYS_DEF,
	parameter int NUM_PLAYERS = kcde_pkg::NUM_PLAYERS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             frame_valid,
	output logic             frame_ready,
	input  kcde_pkg::frame_t frame,
	input  logic             q_full,
	output logic             q_push,
	output kcde_pkg::job_t   q_job
);
	import kcde_pkg::*;

	// Only keys that exist both in the field and in the configuration count.
	localparam int ACT_KEYS = (NUM_KEYS < KEYS_W) ? NUM_KEYS : KEYS_W;
	localparam int PIDX_W   = (NUM_PLAYERS > 1) ? $clog2(NUM_PLAYERS) : 1;

	logic [ACT_KEYS-1:0] last_keys_q [NUM_PLAYERS];
	logic [PLAYER_W-1:0] player_mod;
	logic [PIDX_W-1:0]   pidx;
	logic [ACT_KEYS-1:0] now_keys;
	logic [ACT_KEYS-1:0] diff;
	logic                accept;

	assign frame_ready = !q_full;
	assign accept      = frame_valid && frame_ready;
	assign q_push      = accept;

	// Wrap an out of range player index by repeated subtraction.
	always_comb begin
		player_mod = frame.player;
		for (int i = 0; i < (1 << PLAYER_W) - 1; i++) begin
			if (int'(player_mod) >= NUM_PLAYERS) begin
				player_mod = player_mod - PLAYER_W'(NUM_PLAYERS);
			end
		end
	end

	assign pidx     = PIDX_W'(player_mod);
	assign now_keys = frame.keys[ACT_KEYS-1:0];
	assign diff     = now_keys ^ last_keys_q[pidx];

	// Job for the back: changed keys and the raw movement words.
	always_comb begin
		q_job        = '0;
		q_job.diff   = KEYS_W'(diff);
		q_job.x_bits = frame.x_bits;
		q_job.y_bits = frame.y_bits;
	end

	// Stored key bitmap of every player.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLAYERS; p++) begin
				last_keys_q[p] <= '0;
			end
		end else if (accept) begin
			last_keys_q[pidx] <= now_keys;
		end
	end

endmodule

### hw/rtl/kcde_back.sv
// ----------------------------------------------------------------------------
// kcde_back
// Walks the queue head job and emits one codeword per cycle unless stalled:
// change codewords in ascending key order, the end bit, then x and y.
// ----------------------------------------------------------------------------
module kcde_back #(
	parameter int INDEX_BITS = kcde_pkg::INDEX_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_not_empty,
	input  kcde_pkg::job_t       q_head,
	output logic                 q_pop,
	output logic                 code_valid,
	input  logic                 code_ready,
	output kcde_pkg::code_word_t code_word
);
	import kcde_pkg::*;

	typedef enum logic [2:0] {
		PH_SCAN = 3'b001,
		PH_X    = 3'b010,
		PH_Y    = 3'b100
	} phase_t;

	phase_t             phase_q;
	logic [KEYS_W-1:0]  done_q;
	logic               out_valid_q;
	code_word_t         out_word_q;
	logic [KEYS_W-1:0]  rem;
	logic [KEYS_W-1:0]  low_bit;
	logic [KEY_IDX_W-1:0] low_idx;
	logic               adv;
	code_word_t         next_word;

	assign code_valid = out_valid_q;
	assign code_word  = out_word_q;

	// Emit when a job waits and the output register is free or drains.
	assign adv   = q_not_empty && (!out_valid_q || code_ready);
	assign q_pop = adv && (phase_q == PH_Y);

	// Lowest key that still has to be reported.
	assign rem     = q_head.diff & ~done_q;
	assign low_bit = rem & (~rem + 1'b1);

	always_comb begin
		low_idx = '0;
		for (int i = KEYS_W - 1; i >= 0; i--) begin
			if (rem[i]) begin
				low_idx = KEY_IDX_W'(i);
			end
		end
	end

	// Codeword for the current phase.
	always_comb begin
		next_word = '0;
		case (phase_q)
			PH_SCAN: begin
				if (rem != '0) begin
					next_word.code[INDEX_BITS]     = 1'b1;
					next_word.code[INDEX_BITS-1:0] = INDEX_BITS'(low_idx);
					next_word.code_len             = LEN_W'(INDEX_BITS + 1);
				end else begin
					next_word.code_len = END_LEN;
				end
			end
			PH_X: begin
				next_word.code     = q_head.x_bits;
				next_word.code_len = WORD_LEN;
			end
			PH_Y: begin
				next_word.code     = q_head.y_bits;
				next_word.code_len = WORD_LEN;
				next_word.last     = 1'b1;
			end
			default: begin
				next_word = '0;
			end
		endcase
	end

	// Phase sequence and the mask of keys already reported.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN;
			done_q  <= '0;
		end else if (adv) begin
			case (phase_q)
				PH_SCAN: begin
					if (rem != '0) begin
						done_q <= done_q | low_bit;
					end else begin
						phase_q <= PH_X;
					end
				end
				PH_X: begin
					phase_q <= PH_Y;
				end
				PH_Y: begin
					phase_q <= PH_SCAN;
					done_q  <= '0;
				end
				default: begin
					phase_q <= PH_SCAN;
					done_q  <= '0;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (code_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_word_q <= next_word;
		end
	end

endmodule

### hw/rtl/key_change_delta_encoder_unit.sv
// ----------------------------------------------------------------------------
// key_change_delta_encoder_unit
// Encodes each player frame as change codewords for the keys that differ
// from the player's previous bitmap, an end bit and the two raw words.
//
//   Channel   Direction  Word         Handshake
//   frame     in         frame_t      frame_valid / frame_ready
//   code      out        code_word_t  code_valid / code_ready
//
// A frame with n changed keys yields n + 3 codewords, which the back emits
// one per cycle while the code side takes them.
// The front takes one frame per cycle while the two-entry job queue has room.
// Reset clears the stored bitmaps, empties the queue and clears the output valid flag.
// A stall on the code side fills the queue and then holds off frames.
// ----------------------------------------------------------------------------
module key_change_delta_encoder_unit #(
	parameter int NUM_KEYS    = kcde_pkg::NUM_KEYS_DEF,
	parameter int INDEX_BITS  = kcde_pkg::INDEX_BITS_DEF,
	parameter int NUM_PLAYERS = kcde_pkg::NUM_PLAYERS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	output logic                 frame_ready,
	input  kcde_pkg::frame_t     frame,
	output logic                 code_valid,
	input  logic                 code_ready,
	output kcde_pkg::code_word_t code_word
);
	import kcde_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;
	job_t q_job;
	job_t q_head;

	// Front: classify the frame and update the stored bitmap.
	kcde_front #(
		.NUM_KEYS    (NUM_KEYS),
		.NUM_PLAYERS (NUM_PLAYERS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (q_job)
	);

	// Job queue between front and back.
	kcde_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_job),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty)
	);

	// Back: emit the codewords of the head job.
	kcde_back #(
		.INDEX_BITS (INDEX_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.code_valid  (code_valid),
		.code_ready  (code_ready),
		.code_word   (code_word)
	);

endmodule

### dv/key_change_delta_encoder_unit_tb.sv
// ----------------------------------------------------------------------------
// key_change_delta_encoder_unit_tb
// Self-checking bench for the key change delta encoder. Frames go in through
// a valid/ready sender that works in random bursts. Codewords come out into
// a receiver with its own stall pattern. A bit-accurate encoder model keeps
// the per-player key bitmaps and queues the codewords that each accepted
// frame should produce. Every word that leaves the block is checked against
// that queue, field by field.
// ----------------------------------------------------------------------------
module key_change_delta_encoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kcde_pkg::*;

	localparam int NUM_KEYS     = NUM_KEYS_DEF;
	localparam int INDEX_BITS   = INDEX_BITS_DEF;
	localparam int NUM_PLAYERS  = NUM_PLAYERS_DEF;
	localparam int IDLE_LIMIT   = 1000;
	localparam int DRAIN_CYCLES = 30;

	// Receiver behaviors for the code channel.
	typedef enum int {RX_ALWAYS, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       frame_valid = 1'b0;
	logic       code_ready  = 1'b0;
	frame_t     frame       = '0;
	logic       frame_ready;
	logic       code_valid;
	code_word_t code_word;

	// Encoder model state and the codewords still owed by the block.
	logic [NUM_KEYS-1:0] player_keys [NUM_PLAYERS];
	code_word_t          pending_codes [$];

	// Stimulus bookkeeping.
	logic [KEYS_W-1:0] sent_keys [NUM_PLAYERS];
	int                failures    = 0;
	int                idle_cycles = 0;
	int                burst_left  = 0;
	bit                gaps_on     = 1'b1;
	rx_mode_t          rx_mode     = RX_ALWAYS;
	int                rx_phase    = 0;

	key_change_delta_encoder_unit #(
		.NUM_KEYS(NUM_KEYS),
		.INDEX_BITS(INDEX_BITS),
		.NUM_PLAYERS(NUM_PLAYERS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame(frame),
		.code_valid(code_valid),
		.code_ready(code_ready),
		.code_word(code_word)
	);

	// Free-running clock, 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Encoder model: one change word per differing key in ascending order,
	// then the end bit, the x word and the y word. The player index wraps
	// and key indexes are cut to the index field width.
	task automatic encode_frame(input frame_t f);
		int                  p;
		logic [NUM_KEYS-1:0] now;
		logic [NUM_KEYS-1:0] changed;
		code_word_t          w;
		p       = int'(f.player) % NUM_PLAYERS;
		now     = NUM_KEYS'(f.keys);
		changed = now ^ player_keys[p];
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (changed[i]) begin
				w.code     = CODE_W'((1 << INDEX_BITS) | (i & ((1 << INDEX_BITS) - 1)));
				w.code_len = LEN_W'(1 + INDEX_BITS);
				w.last     = 1'b0;
				pending_codes.push_back(w);
			end
		end
		player_keys[p] = now;
		w.code     = '0;
		w.code_len = LEN_W'(1);
		w.last     = 1'b0;
		pending_codes.push_back(w);
		w.code     = f.x_bits;
		w.code_len = LEN_W'(32);
		pending_codes.push_back(w);
		w.code     = f.y_bits;
		w.last     = 1'b1;
		pending_codes.push_back(w);
	endtask

	// Monitor: predict on each accepted frame, check each accepted word,
	// and stop the run if the channels stay quiet for too long.
	always @(posedge clk) begin
		code_word_t exp_word;
		if (arst_n) begin
			if (frame_valid && frame_ready) begin
				encode_frame(frame);
			end
			if (code_valid && code_ready) begin
				if (pending_codes.size() == 0) begin
					$error("unexpected code word %h (len %0d, last %0b)",
						code_word.code, code_word.code_len, code_word.last);
					failures++;
				end else begin
					exp_word = pending_codes.pop_front();
					if (code_word.code !== exp_word.code) begin
						$error("code: expected %h, actual %h", exp_word.code, code_word.code);
						failures++;
					end
					if (code_word.code_len !== exp_word.code_len) begin
						$error("code_len: expected %0d, actual %0d",
							exp_word.code_len, code_word.code_len);
						failures++;
					end
					if (code_word.last !== exp_word.last) begin
						$error("last: expected %0b, actual %0b", exp_word.last, code_word.last);
						failures++;
					end
				end
			end
			if ((frame_valid && frame_ready) || (code_valid && code_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver: ready follows the current stall behavior.
	always @(posedge clk) begin
		rx_phase++;
		case (rx_mode)
			RX_ALWAYS: begin
				code_ready <= 1'b1;
			end
			RX_LIGHT: begin
				code_ready <= ($urandom_range(0, 3) != 0);
			end
			RX_HEAVY: begin
				code_ready <= ($urandom_range(0, 3) == 0);
			end
			default: begin
				code_ready <= ((rx_phase % 9) >= 4);
			end
		endcase
	end

	function automatic frame_t make_frame(input int p, input int k, input logic [31:0] x,
			input logic [31:0] y);
		frame_t f;
		f.player = PLAYER_W'(p);
		f.keys   = KEYS_W'(k);
		f.x_bits = x;
		f.y_bits = y;
		return f;
	endfunction

	// Sends one frame word; valid stays high afterwards unless a gap follows.
	task automatic send_frame(input frame_t f);
		if (gaps_on && burst_left == 0) begin
			frame_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) :
				$urandom_range(1, 8);
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		frame       <= f;
		frame_valid <= 1'b1;
		sent_keys[f.player] = f.keys;
		@(posedge clk);
		while (!frame_ready) @(posedge clk);
	endtask

	// Stops sending and waits until every owed word has come out.
	task automatic wait_drained();
		frame_valid <= 1'b0;
		@(posedge clk);
		while (pending_codes.size() != 0) @(posedge clk);
	endtask

	// Random frame, often one to three key flips from what the player last sent,
	// sometimes no change, an extreme or inverted bitmap or a fully random one.
	function automatic frame_t random_frame();
		int                p;
		int                sel;
		logic [KEYS_W-1:0] k;
		p   = $urandom_range(0, NUM_PLAYERS - 1);
		sel = $urandom_range(0, 19);
		k   = sent_keys[p];
		if (sel < 8) begin
			repeat ($urandom_range(1, 3)) k[$urandom_range(0, KEYS_W - 1)] ^= 1'b1;
		end else if (sel < 11) begin
			k = sent_keys[p];
		end else if (sel < 13) begin
			k = ($urandom_range(0, 1) != 0) ? '1 : '0;
		end else if (sel < 14) begin
			k = ~sent_keys[p];
		end else begin
			k = KEYS_W'($urandom);
		end
		return make_frame(p, int'(k), $urandom, $urandom);
	endfunction

	// Extremes of every field, frames on each player, no-change and all-change frames.
	task automatic test_directed();
		rx_mode = RX_ALWAYS;
		send_frame(make_frame(0, 'h000, 32'h0000_0000, 32'h0000_0000));
		send_frame(make_frame(0, 'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_frame(make_frame(0, 'h3FF, 32'h8000_0000, 32'h7FFF_FFFF));
		send_frame(make_frame(0, 'h000, 32'h7FFF_FFFF, 32'h8000_0000));
		send_frame(make_frame(1, 'h001, 32'h0000_0001, 32'hFFFF_FFFE));
		send_frame(make_frame(1, 'h200, 32'hA5A5_A5A5, 32'h5A5A_5A5A));
		send_frame(make_frame(2, 'h155, 32'h5555_5555, 32'hAAAA_AAAA));
		send_frame(make_frame(2, 'h2AA, 32'hAAAA_AAAA, 32'h5555_5555));
		send_frame(make_frame(3, 'h3FF, 32'h3F80_0000, 32'hBF80_0000));
		send_frame(make_frame(3, 'h3FF, 32'h0000_0000, 32'hFFFF_FFFF));
		send_frame(make_frame(1, 'h000, 32'hFFFF_FFFF, 32'h0000_0000));
		send_frame(make_frame(3, 'h000, 32'h1234_5678, 32'h8765_4321));
		send_frame(make_frame(2, 'h000, 32'hDEAD_BEEF, 32'hCAFE_F00D));
		wait_drained();
	endtask

	// Random frames with light receiver stalls and one full pause midway.
	task automatic test_random_frames(input int count);
		rx_mode = RX_LIGHT;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2) begin
				wait_drained();
			end
			send_frame(random_frame());
		end
	endtask

	// Heavy and patterned receiver stalls that fill the job queue.
	task automatic test_backpressure(input int count);
		for (int n = 0; n < count; n++) begin
			rx_mode = (n < count / 2) ? RX_HEAVY : RX_PATTERN;
			send_frame(random_frame());
		end
	endtask

	// Back-to-back frames with the receiver always ready.
	task automatic test_full_rate(input int count);
		gaps_on = 1'b0;
		rx_mode = RX_ALWAYS;
		for (int n = 0; n < count; n++) begin
			send_frame(random_frame());
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		foreach (player_keys[p]) begin
			player_keys[p] = '0;
			sent_keys[p]   = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_frames(300);
		test_backpressure(90);
		test_full_rate(64);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending_codes.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/kcde_pkg.sv
hw/rtl/kcde_queue.sv
hw/rtl/kcde_front.sv
hw/rtl/kcde_back.sv
hw/rtl/key_change_delta_encoder_unit.sv
dv/key_change_delta_encoder_unit_tb.sv
